FILE: sv/rvx_pkg.sv
// Shared types, operation codes and constants for the RV32IM execute unit.
package rvx_pkg;
	localparam int unsigned REG_COUNT_DEF = 32;
	localparam int unsigned XLEN = 32;
	localparam logic [31:0] PC_STEP = 32'd4;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_SLL = 5'd2, OP_SLT = 5'd3, OP_SLTU = 5'd4,
		OP_XOR = 5'd5, OP_SRL = 5'd6, OP_SRA = 5'd7, OP_OR = 5'd8, OP_AND = 5'd9,
		OP_MUL = 5'd10, OP_MULH = 5'd11, OP_MULHSU = 5'd12, OP_MULHU = 5'd13,
		OP_DIV = 5'd14, OP_DIVU = 5'd15, OP_REM = 5'd16, OP_REMU = 5'd17,
		OP_LUI = 5'd18, OP_AUIPC = 5'd19, OP_JAL = 5'd20, OP_JALR = 5'd21,
		OP_BEQ = 5'd22, OP_BNE = 5'd23, OP_BLT = 5'd24, OP_BGE = 5'd25,
		OP_BLTU = 5'd26, OP_BGEU = 5'd27, OP_FENCE = 5'd28
	} op_t;

	typedef enum logic [1:0] {
		CLS_SIMPLE = 2'd0,
		CLS_MUL = 2'd1,
		CLS_DIV = 2'd2
	} cls_t;

	typedef struct packed {
		logic [4:0] mode;
		cls_t cls;
		logic use_imm;
		logic [4:0] dest_index;
		logic [4:0] src1_index;
		logic [4:0] src2_index;
		logic [31:0] immediate;
		logic [31:0] pc_value;
	} uop_t;
endpackage

FILE: sv/rvx_front.sv
// Front end: accepts decoded instructions, classifies them and holds a two-entry queue.
module rvx_front import rvx_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [4:0] mode,
	input logic use_imm,
	input logic [4:0] dest_index,
	input logic [4:0] src1_index,
	input logic [4:0] src2_index,
	input logic [31:0] immediate,
	input logic [31:0] pc_value,
	output logic q_valid,
	input logic q_ready,
	output uop_t q_uop
);
	uop_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	uop_t u;
	logic push, pop;

	always_comb begin
		u.mode = mode;
		u.use_imm = use_imm;
		u.dest_index = dest_index;
		u.src1_index = src1_index;
		u.src2_index = src2_index;
		u.immediate = immediate;
		u.pc_value = pc_value;
		if (mode >= OP_MUL && mode <= OP_MULHU) begin
			u.cls = CLS_MUL;
		end else if (mode >= OP_DIV && mode <= OP_REMU) begin
			u.cls = CLS_DIV;
		end else begin
			u.cls = CLS_SIMPLE;
		end
	end

	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_uop = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= u;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count did not grow on push");
endmodule

FILE: sv/rvx_back.sv
// Back end: register file, ALU, multiplier, serial divider and result register.
module rvx_back import rvx_pkg::*; #(
	parameter int unsigned REG_COUNT = REG_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input uop_t q_uop,
	output logic out_valid,
	input logic out_ready,
	output logic write_enable,
	output logic [31:0] write_value,
	output logic redirect,
	output logic [31:0] target_address
);
	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} st_t;

	st_t st_q;
	logic [31:0] rf_q [REG_COUNT];
	logic [REG_COUNT-1:0] rfv_q;
	uop_t uop_q;
	logic [31:0] a_q, b_q;
	logic signed [65:0] prod_q;
	logic [31:0] quo_q, rem_q, dvd_q, dvs_q;
	logic [5:0] cnt_q;
	logic res_we_q, res_rd_q;
	logic [31:0] res_val_q, res_tgt_q;
	logic out_full_q;

	logic [31:0] rs1, rs2, opb, simple_val, tgt, fin_val, divres;
	logic wr, rd_ok, cond, red, finish, res_load;
	logic [32:0] rtrial;
	logic [4:0] sh;

	function automatic logic [31:0] rd_reg(input logic [4:0] idx,
		input logic [REG_COUNT-1:0] v, input logic [31:0] d);
		logic [31:0] r;
		r = 32'd0;
		if (idx != 5'd0 && 32'(idx) < REG_COUNT && v[idx[$clog2(REG_COUNT)-1:0]]) r = d;
		return r;
	endfunction

	function automatic logic rd_ok_q();
		return uop_q.dest_index != 5'd0 && 32'(uop_q.dest_index) < REG_COUNT;
	endfunction

	assign rs1 = rd_reg(q_uop.src1_index, rfv_q,
		rf_q[q_uop.src1_index[$clog2(REG_COUNT)-1:0]]);
	assign rs2 = rd_reg(q_uop.src2_index, rfv_q,
		rf_q[q_uop.src2_index[$clog2(REG_COUNT)-1:0]]);
	assign opb = (q_uop.use_imm && q_uop.mode <= OP_REMU) ? q_uop.immediate : rs2;
	assign sh = opb[4:0];

	always_comb begin
		simple_val = 32'd0;
		wr = 1'b1;
		cond = 1'b0;
		red = 1'b0;
		tgt = 32'd0;
		case (op_t'(q_uop.mode))
			OP_ADD: simple_val = rs1 + opb;
			OP_SUB: simple_val = rs1 - opb;
			OP_SLL: simple_val = rs1 << sh;
			OP_SLT: simple_val = {31'd0, $signed(rs1) < $signed(opb)};
			OP_SLTU: simple_val = {31'd0, rs1 < opb};
			OP_XOR: simple_val = rs1 ^ opb;
			OP_SRL: simple_val = rs1 >> sh;
			OP_SRA: simple_val = 32'($signed(rs1) >>> sh);
			OP_OR: simple_val = rs1 | opb;
			OP_AND: simple_val = rs1 & opb;
			OP_LUI: simple_val = q_uop.immediate;
			OP_AUIPC: simple_val = q_uop.pc_value + q_uop.immediate;
			OP_JAL: begin
				simple_val = q_uop.pc_value + PC_STEP;
				red = 1'b1;
				tgt = q_uop.pc_value + q_uop.immediate;
			end
			OP_JALR: begin
				simple_val = q_uop.pc_value + PC_STEP;
				red = 1'b1;
				tgt = (rs1 + q_uop.immediate) & ~32'd1;
			end
			OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
				wr = 1'b0;
				case (op_t'(q_uop.mode))
					OP_BEQ: cond = rs1 == rs2;
					OP_BNE: cond = rs1 != rs2;
					OP_BLT: cond = $signed(rs1) < $signed(rs2);
					OP_BGE: cond = !($signed(rs1) < $signed(rs2));
					OP_BLTU: cond = rs1 < rs2;
					default: cond = rs1 >= rs2;
				endcase
				red = cond;
				tgt = cond ? q_uop.pc_value + q_uop.immediate : 32'd0;
			end
			default: wr = 1'b0;
		endcase
	end

	assign rd_ok = q_uop.dest_index != 5'd0 && 32'(q_uop.dest_index) < REG_COUNT;
	assign q_ready = (st_q == ST_IDLE) && (!out_full_q || out_ready);
	assign rtrial = {rem_q, dvd_q[31]} - {1'b0, dvs_q};

	always_comb begin
		logic sgn;
		logic [31:0] q, r;
		sgn = uop_q.mode == OP_DIV || uop_q.mode == OP_REM;
		q = (sgn && (a_q[31] ^ b_q[31])) ? -quo_q : quo_q;
		r = (sgn && a_q[31]) ? -rem_q : rem_q;
		if (b_q == 32'd0) begin
			divres = (uop_q.mode == OP_DIV || uop_q.mode == OP_DIVU) ? 32'hFFFF_FFFF : a_q;
		end else if (uop_q.mode == OP_DIV || uop_q.mode == OP_DIVU) begin
			divres = q;
		end else begin
			divres = r;
		end
	end

	always_comb begin
		case (op_t'(uop_q.mode))
			OP_MUL: fin_val = prod_q[31:0];
			OP_MULH, OP_MULHSU, OP_MULHU: fin_val = prod_q[63:32];
			default: fin_val = divres;
		endcase
	end

	assign finish = (st_q == ST_MUL) || (st_q == ST_DIV && cnt_q == 6'd32);
	assign res_load = (q_valid && q_ready && q_uop.cls == CLS_SIMPLE) || finish;

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			uop_q <= q_uop;
			a_q <= rs1;
			b_q <= opb;
			dvd_q <= ((q_uop.mode == OP_DIV || q_uop.mode == OP_REM) && rs1[31]) ? -rs1 : rs1;
			dvs_q <= ((q_uop.mode == OP_DIV || q_uop.mode == OP_REM) && opb[31]) ? -opb : opb;
			rem_q <= 32'd0;
			quo_q <= 32'd0;
			prod_q <= $signed({q_uop.mode != OP_MULHU && rs1[31], rs1}) *
				$signed({(q_uop.mode == OP_MULH) && opb[31], opb});
		end else if (st_q == ST_DIV && cnt_q != 6'd32) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!rtrial[32]) begin
				rem_q <= rtrial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], dvd_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (q_valid && q_ready && q_uop.cls == CLS_SIMPLE) begin
			res_we_q <= wr && rd_ok;
			res_val_q <= (wr && rd_ok) ? simple_val : 32'd0;
			res_rd_q <= red;
			res_tgt_q <= tgt;
		end else if (finish) begin
			res_we_q <= rd_ok_q();
			res_val_q <= rd_ok_q() ? fin_val : 32'd0;
			res_rd_q <= 1'b0;
			res_tgt_q <= 32'd0;
		end
		if (q_valid && q_ready && q_uop.cls == CLS_SIMPLE && wr && rd_ok) begin
			rf_q[q_uop.dest_index[$clog2(REG_COUNT)-1:0]] <= simple_val;
		end else if (finish && rd_ok_q()) begin
			rf_q[uop_q.dest_index[$clog2(REG_COUNT)-1:0]] <= fin_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rfv_q <= '0;
			cnt_q <= 6'd0;
			out_full_q <= 1'b0;
		end else begin
			out_full_q <= res_load || (out_full_q && !out_ready);
			case (st_q)
				ST_IDLE: begin
					if (q_valid && q_ready) begin
						cnt_q <= 6'd0;
						case (q_uop.cls)
							CLS_MUL: st_q <= ST_MUL;
							CLS_DIV: st_q <= ST_DIV;
							default: begin
								if (wr && rd_ok)
									rfv_q[q_uop.dest_index[$clog2(REG_COUNT)-1:0]] <= 1'b1;
							end
						endcase
					end
				end
				ST_MUL, ST_DIV: begin
					if (st_q == ST_DIV && cnt_q != 6'd32) cnt_q <= cnt_q + 6'd1;
					if (finish) begin
						st_q <= ST_IDLE;
						if (rd_ok_q()) rfv_q[uop_q.dest_index[$clog2(REG_COUNT)-1:0]] <= 1'b1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_full_q;
	assign write_enable = res_we_q;
	assign write_value = res_val_q;
	assign redirect = res_rd_q;
	assign target_address = res_tgt_q;

	assert property (@(posedge clk) disable iff (!arst_n) (st_q != ST_IDLE) |-> !q_ready)
		else $error("issue while a long operation is running");
	assert property (@(posedge clk) disable iff (!arst_n) finish |-> !out_full_q)
		else $error("result produced over an untaken one");
	assert property (@(posedge clk) disable iff (!arst_n) rfv_q[0] == 1'b0)
		else $error("register zero marked written");
endmodule

FILE: sv/rv32im_integer_execute_unit.sv
// Top level of the RV32IM integer execute unit.
// Simple operations: result passes through the front queue and the result register, one per cycle if taken.
// Multiplies: operands pass through the front queue into the registered 33x33 product, then the result register.
// Divide and remainder: the one-bit-per-cycle restoring divider; no new instruction issues until it finishes.
// Reset clears the queue, the state machine and all register-file valid bits (reads give zero).
module rv32im_integer_execute_unit import rvx_pkg::*; #(
	parameter int unsigned REG_COUNT = REG_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// mode[4:0], use_imm[5], dest_index[10:6], src1_index[15:11], src2_index[20:16],
	// immediate[52:21], pc_value[84:53], zero fill to 88 bits.
	input logic [87:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// write_enable[0], write_value[32:1], redirect[33], target_address[65:34], zero fill.
	output logic [71:0] m_tdata
);
	logic q_valid, q_ready;
	uop_t q_uop;
	logic we, rd;
	logic [31:0] wv, ta;

	rvx_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.mode(s_tdata[4:0]), .use_imm(s_tdata[5]), .dest_index(s_tdata[10:6]),
		.src1_index(s_tdata[15:11]), .src2_index(s_tdata[20:16]),
		.immediate(s_tdata[52:21]), .pc_value(s_tdata[84:53]),
		.q_valid(q_valid), .q_ready(q_ready), .q_uop(q_uop)
	);

	rvx_back #(.REG_COUNT(REG_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_uop(q_uop),
		.out_valid(m_tvalid), .out_ready(m_tready), .write_enable(we), .write_value(wv),
		.redirect(rd), .target_address(ta)
	);

	assign m_tdata = {6'd0, ta, rd, wv, we};
endmodule

FILE: tb/rv32im_integer_execute_unit_tb.sv
// Self-checking testbench for the RV32IM integer execute unit with its own instruction predictor.
module rv32im_integer_execute_unit_tb;
	import rvx_pkg::*;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] imm;
		logic [4:0] rs2;
		logic [4:0] rs1;
		logic [4:0] rd;
		logic use_imm;
		logic [4:0] mode;
	} instr_t;

	typedef struct packed {
		logic [31:0] target;
		logic redir;
		logic [31:0] wval;
		logic we;
	} outcome_t;

	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [87:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [71:0] m_tdata;

	instr_t pending_instrs[$];
	outcome_t expected_outcomes[$];
	logic [31:0] arch_regs[32];
	int errors = 0;
	int sent = 0;
	int retired = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit stimulus_done = 1'b0;
	bit drain_request = 1'b0;
	bit long_hold_request = 1'b0;

	rv32im_integer_execute_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] read_arch(logic [4:0] idx);
		return (idx == 5'd0) ? 32'd0 : arch_regs[idx];
	endfunction

	function automatic logic [31:0] compute_alu(logic [4:0] mode, logic [31:0] a, logic [31:0] b);
		logic [63:0] prod;
		logic [31:0] q;
		logic [31:0] r;
		logic [31:0] ua;
		logic [31:0] ub;
		logic ovf;
		prod = '0;
		ovf = (a == 32'h8000_0000) && (b == 32'hFFFF_FFFF);
		ua = a[31] ? -a : a;
		ub = b[31] ? -b : b;
		case (mode)
			OP_ADD: return a + b;
			OP_SUB: return a - b;
			OP_SLL: return a << b[4:0];
			OP_SLT: return {31'd0, $signed(a) < $signed(b)};
			OP_SLTU: return {31'd0, a < b};
			OP_XOR: return a ^ b;
			OP_SRL: return a >> b[4:0];
			OP_SRA: return $unsigned($signed(a) >>> b[4:0]);
			OP_OR: return a | b;
			OP_AND: return a & b;
			OP_MUL: return a * b;
			OP_MULH: begin
				prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				return prod[63:32];
			end
			OP_MULHSU: begin
				prod = {{32{a[31]}}, a} * {32'd0, b};
				return prod[63:32];
			end
			OP_MULHU: begin
				prod = {32'd0, a} * {32'd0, b};
				return prod[63:32];
			end
			OP_DIV: begin
				if (b == 0) return 32'hFFFF_FFFF;
				if (ovf) return a;
				q = ua / ub;
				return (a[31] ^ b[31]) ? -q : q;
			end
			OP_DIVU: return (b == 0) ? 32'hFFFF_FFFF : a / b;
			OP_REM: begin
				if (b == 0) return a;
				if (ovf) return 32'd0;
				r = ua % ub;
				return a[31] ? -r : r;
			end
			default: return (b == 0) ? a : a % b;
		endcase
	endfunction

	function automatic outcome_t execute_instr(instr_t ins);
		outcome_t o;
		logic [31:0] a;
		logic [31:0] b;
		logic cond;
		o = '0;
		cond = 1'b0;
		a = read_arch(ins.rs1);
		b = read_arch(ins.rs2);
		if (ins.mode <= OP_REMU) begin
			o.we = 1'b1;
			o.wval = compute_alu(ins.mode, a, ins.use_imm ? ins.imm : b);
		end else if (ins.mode == OP_LUI) begin
			o.we = 1'b1;
			o.wval = ins.imm;
		end else if (ins.mode == OP_AUIPC) begin
			o.we = 1'b1;
			o.wval = ins.pc + ins.imm;
		end else if (ins.mode == OP_JAL) begin
			o.we = 1'b1;
			o.wval = ins.pc + PC_STEP;
			o.redir = 1'b1;
			o.target = ins.pc + ins.imm;
		end else if (ins.mode == OP_JALR) begin
			o.we = 1'b1;
			o.wval = ins.pc + PC_STEP;
			o.redir = 1'b1;
			o.target = (a + ins.imm) & ~32'd1;
		end else if (ins.mode >= OP_BEQ && ins.mode <= OP_BGEU) begin
			case (ins.mode)
				OP_BEQ: cond = a == b;
				OP_BNE: cond = a != b;
				OP_BLT: cond = $signed(a) < $signed(b);
				OP_BGE: cond = !($signed(a) < $signed(b));
				OP_BLTU: cond = a < b;
				default: cond = a >= b;
			endcase
			if (cond) begin
				o.redir = 1'b1;
				o.target = ins.pc + ins.imm;
			end
		end
		if (o.we && ins.rd == 5'd0)
			o.we = 1'b0;
		if (o.we)
			arch_regs[ins.rd] = o.wval;
		else
			o.wval = '0;
		return o;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 40);
			5: return -$urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t make_instr(logic [4:0] mode, logic use_imm, logic [4:0] rd,
			logic [4:0] rs1, logic [4:0] rs2, logic [31:0] imm, logic [31:0] pc);
		instr_t ins;
		ins.mode = mode;
		ins.use_imm = use_imm;
		ins.rd = rd;
		ins.rs1 = rs1;
		ins.rs2 = rs2;
		ins.imm = imm;
		ins.pc = pc;
		return ins;
	endfunction

	function automatic instr_t random_instr();
		logic [4:0] mode;
		mode = ($urandom_range(0, 3) == 0) ? OP_LUI : 5'($urandom_range(0, OP_FENCE));
		if ($urandom_range(0, 40) == 0)
			mode = 5'($urandom_range(29, 31));
		return make_instr(mode, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
			5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), pick_value(), $urandom);
	endfunction

	initial begin
		for (int i = 0; i < 32; i++)
			arch_regs[i] = '0;
		pending_instrs.push_back(make_instr(OP_LUI, 1'b0, 5'd1, 5'd0, 5'd0, 32'h8000_0000, 0));
		pending_instrs.push_back(make_instr(OP_LUI, 1'b1, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF, 0));
		pending_instrs.push_back(make_instr(OP_LUI, 1'b0, 5'd0, 5'd0, 5'd0, 32'h1234_5678, 0));
		pending_instrs.push_back(make_instr(OP_ADD, 1'b0, 5'd3, 5'd0, 5'd0, 0, 0));
		pending_instrs.push_back(make_instr(OP_DIV, 1'b0, 5'd4, 5'd1, 5'd2, 0, 0));
		pending_instrs.push_back(make_instr(OP_REM, 1'b0, 5'd5, 5'd1, 5'd2, 0, 0));
		pending_instrs.push_back(make_instr(OP_DIV, 1'b0, 5'd6, 5'd1, 5'd3, 0, 0));
		pending_instrs.push_back(make_instr(OP_DIVU, 1'b1, 5'd7, 5'd2, 5'd0, 0, 0));
		pending_instrs.push_back(make_instr(OP_REM, 1'b1, 5'd8, 5'd1, 5'd0, 0, 0));
		pending_instrs.push_back(make_instr(OP_REMU, 1'b0, 5'd9, 5'd2, 5'd0, 0, 0));
		pending_instrs.push_back(make_instr(OP_SRA, 1'b1, 5'd10, 5'd1, 5'd0, 32'hFFFF_FFFF, 0));
		pending_instrs.push_back(make_instr(OP_SLL, 1'b1, 5'd11, 5'd2, 5'd0, 32'h0000_0021, 0));
		pending_instrs.push_back(make_instr(OP_MULH, 1'b0, 5'd12, 5'd1, 5'd1, 0, 0));
		pending_instrs.push_back(make_instr(OP_MULHSU, 1'b0, 5'd13, 5'd1, 5'd2, 0, 0));
		pending_instrs.push_back(make_instr(OP_MULHU, 1'b0, 5'd14, 5'd2, 5'd2, 0, 0));
		pending_instrs.push_back(make_instr(OP_JALR, 1'b0, 5'd2, 5'd2, 5'd0, 32'd3,
			32'hFFFF_FFFC));
		pending_instrs.push_back(make_instr(OP_JAL, 1'b1, 5'd31, 5'd0, 5'd0, 32'h8000_0000,
			32'hFFFF_FFFF));
		for (int m = OP_BEQ; m <= OP_BGEU; m++)
			pending_instrs.push_back(make_instr(5'(m), 1'b1, 5'd15, 5'd1, 5'd3, -32'd8,
				32'h100));
		pending_instrs.push_back(make_instr(OP_FENCE, 1'b1, 5'd16, 5'd1, 5'd1, 1, 0));
		pending_instrs.push_back(make_instr(5'd31, 1'b1, 5'd17, 5'd1, 5'd1, 1, 0));
		for (int i = 0; i < 900; i++)
			pending_instrs.push_back(random_instr());
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stimulus: bursts with random gaps; pauses after item 300 until drained, asks for a long output hold at 600.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_outcomes.push_back(execute_instr(instr_t'(s_tdata[84:0])));
				sent++;
				if (sent == 300)
					drain_request = 1'b1;
				if (sent == 600)
					long_hold_request = 1'b1;
			end
			if (drain_request && expected_outcomes.size() == 0)
				drain_request = 1'b0;
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (pending_instrs.size() == 0 || drain_request) begin
				s_tvalid <= 1'b0;
				if (pending_instrs.size() == 0)
					stimulus_done = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				s_tdata <= {3'd0, pending_instrs.pop_front()};
				s_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = outcome_t'(m_tdata[65:0]);
				if (expected_outcomes.size() == 0) begin
					$error("result transaction with nothing expected: %h", got);
					errors++;
				end else begin
					want = expected_outcomes.pop_front();
					retired++;
					if (got.we !== want.we) begin
						$error("write_enable exp %0d got %0d", want.we, got.we);
						errors++;
					end
					if (got.wval !== want.wval) begin
						$error("write_value exp %h got %h", want.wval, got.wval);
						errors++;
					end
					if (got.redir !== want.redir) begin
						$error("redirect exp %0d got %0d", want.redir, got.redir);
						errors++;
					end
					if (got.target !== want.target) begin
						$error("target_address exp %h got %h", want.target, got.target);
						errors++;
					end
				end
			end
			if (long_hold_request) begin
				long_hold_request = 1'b0;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (cycles % 64 < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
			end
		end
	end

	initial begin
		while (cycles < LIMIT && !(stimulus_done && expected_outcomes.size() == 0)) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= LIMIT) begin
			$display("rv32im_integer_execute_unit_tb: FAIL");
			$finish;
		end else begin
			repeat (50) @(posedge clk);
			$display("Ran %0d instructions, %0d results checked, all operation classes,", sent,
				retired);
			$display("with bursty input, output stalls, a drain pause and a long hold.");
			if (errors == 0 && expected_outcomes.size() == 0)
				$display("rv32im_integer_execute_unit_tb: PASS");
			else
				$display("rv32im_integer_execute_unit_tb: FAIL");
			$finish;
		end
	end
endmodule

FILE: rv32im_integer_execute_unit.f
sv/rvx_pkg.sv
sv/rvx_front.sv
sv/rvx_back.sv
sv/rv32im_integer_execute_unit.sv
tb/rv32im_integer_execute_unit_tb.sv
